// ----- rtl/bpp_pkg.sv -----
// Shared types, constants and fixed-point helpers for the Boris pusher.
package bpp_pkg;

    localparam int DW = 32;             // word width
    localparam int FB = 16;             // fractional bits
    localparam int QW = DW + 2;         // quotient width of the S divider
    localparam int NW = DW + FB + 2;    // dividend width of the S divider
    localparam int CFG_IDX_W = 8;

    typedef logic signed [DW-1:0] t_word;
    typedef t_word [2:0] t_vec;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    typedef struct packed {
        logic            neg;
        logic [2*DW-1:0] mag;
    } t_prod;

    typedef struct packed {
        t_word val;
        logic  ov;
    } t_res;

    localparam t_cfg_idx REG_ROT_SCALE = t_cfg_idx'(0);
    localparam t_cfg_idx REG_TIME_STEP = t_cfg_idx'(1);

    localparam t_word MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam t_word MINV = {1'b1, {(DW-1){1'b0}}};
    localparam t_word ONEQ = t_word'(1 << FB);

    localparam logic signed [DW+1:0] MAXW = (DW+2)'(MAXV);
    localparam logic signed [DW+1:0] MINW = (DW+2)'(MINV);

    localparam logic [2*DW-1:0] RND     = {{(2*DW-1){1'b0}}, 1'b1} << (FB - 1);
    localparam logic [2*DW-1:0] LIM_POS = (2*DW)'(MAXV);
    localparam logic [2*DW-1:0] LIM_NEG = LIM_POS + 1'b1;

    // component indices for a cross product: o[i] = a[j]*b[k] - a[k]*b[j]
    localparam int NX1 [3] = '{1, 2, 0};
    localparam int NX2 [3] = '{2, 0, 1};

    function automatic logic [DW-1:0] mag_of(input t_word a);
        logic [DW-1:0] ua;
        ua = a;
        return a[DW-1] ? (~ua + 1'b1) : ua;
    endfunction

    function automatic t_prod mul_raw(input t_word a, input t_word b);
        t_prod p;
        p.neg = a[DW-1] ^ b[DW-1];
        p.mag = mag_of(a) * mag_of(b);
        return p;
    endfunction

    // round to nearest, ties away from zero, then clamp
    function automatic t_res round_sat(input t_prod p);
        logic [2*DW-1:0] sh;
        logic [2*DW-1:0] lim;
        t_res r;
        sh   = (p.mag + RND) >> FB;
        lim  = p.neg ? LIM_NEG : LIM_POS;
        r.ov = sh > lim;
        if (r.ov) begin
            sh = lim;
        end
        r.val = p.neg ? t_word'(~sh[DW-1:0] + 1'b1) : t_word'(sh[DW-1:0]);
        return r;
    endfunction

    function automatic t_res sat_wide(input logic signed [DW+1:0] s);
        t_res r;
        r.ov = 1'b1;
        if (s > MAXW) begin
            r.val = MAXV;
        end else if (s < MINW) begin
            r.val = MINV;
        end else begin
            r.val = s[DW-1:0];
            r.ov  = 1'b0;
        end
        return r;
    endfunction

    function automatic t_res add_sat(input t_word a, input t_word b);
        return sat_wide((DW+2)'(a) + (DW+2)'(b));
    endfunction

    function automatic t_res sub_sat(input t_word a, input t_word b);
        return sat_wide((DW+2)'(a) - (DW+2)'(b));
    endfunction

    function automatic t_res neg_sat(input t_word a);
        return sat_wide(-(DW+2)'(a));
    endfunction

endpackage

// ----- rtl/bpp_div.sv -----
// Pipelined restoring divider: quotient of (num << (FB+1)) by den, one bit a stage.
module bpp_div
    import bpp_pkg::*;
(
    input  logic          i_clk,
    input  logic [DW:0]   i_num,
    input  logic [DW-2:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [NW-1:0] dividend;
    logic [DW-2:0] r_rem [QW];
    logic [QW-1:0] r_nlo [QW];
    logic [DW-2:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-2:0] n_rem [QW];
    logic [QW-1:0] n_quo [QW];

    assign dividend = {i_num, {(FB+1){1'b0}}};

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-2:0] src_rem;
        logic [QW-1:0] src_nlo;
        logic [DW-2:0] src_den;
        logic [QW-1:0] src_quo;
        logic [DW-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            // top FB bits of the dividend are below den since the quotient fits QW bits
            assign src_rem = (DW-1)'(dividend[NW-1:QW]);
            assign src_nlo = dividend[QW-1:0];
            assign src_den = i_den;
            assign src_quo = '0;
        end else begin : g_next
            assign src_rem = r_rem[k-1];
            assign src_nlo = r_nlo[k-1];
            assign src_den = r_den[k-1];
            assign src_quo = r_quo[k-1];
        end

        always_comb begin
            trial    = {src_rem, src_nlo[QW-1-k]};
            ge       = trial >= {1'b0, src_den};
            n_rem[k] = ge ? (DW-1)'(trial - {1'b0, src_den}) : trial[DW-2:0];
            n_quo[k] = {src_quo[QW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem[k];
            r_nlo[k] <= src_nlo;
            r_den[k] <= src_den;
            r_quo[k] <= n_quo[k];
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ----- rtl/boris_particle_push.sv -----
// Boris particle pusher top level: one Q16.16 particle step per cycle, fully pipelined.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+--------------------------------
//  command  | in        | start, busy (transfer when  | i_pos_*, i_vel_*, i_flow_*,
//           |           | start high and busy low)    | i_field_*
//  result   | out       | o_done, one-cycle strobe    | o_new_pos_*, o_new_vel_*,
//           |           |                             | o_overflow
//  config   | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One particle enters every cycle; busy stays low. Each result leaves after its
// transfer has passed, in order, 8 stages of field, kick and first rotation math,
// QW stages of the bit-serial S divider, 6 stages of second rotation and position
// advance. The divider's one quotient bit per stage sets the latency.
// Synchronous reset clears every valid bit and loads rotation_scale = 0 and
// time_step = 1.0. The receiver cannot stall, so nothing in the pipe ever holds.
module boris_particle_push
    import bpp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_word    i_pos_x,
    input  t_word    i_pos_y,
    input  t_word    i_pos_z,
    input  t_word    i_vel_x,
    input  t_word    i_vel_y,
    input  t_word    i_vel_z,
    input  t_word    i_flow_x,
    input  t_word    i_flow_y,
    input  t_word    i_flow_z,
    input  t_word    i_field_x,
    input  t_word    i_field_y,
    input  t_word    i_field_z,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  t_cfg_idx i_cfg_index,
    input  t_word    i_cfg_data,
    output logic     o_done,
    output t_word    o_new_pos_x,
    output t_word    o_new_pos_y,
    output t_word    o_new_pos_z,
    output t_word    o_new_vel_x,
    output t_word    o_new_vel_y,
    output t_word    o_new_vel_z,
    output logic     o_overflow
);

    localparam int LAT = QW + 14;

    // sideband carried alongside the divider
    typedef struct packed {
        t_vec       x;
        t_vec       u;
        t_vec       r;
        t_vec       vp;
        logic [2:0] tneg;
        logic       ov;
    } t_side;

    logic          in_acc;
    t_vec          in_pos, in_vel, in_flow, in_field;

    // configuration registers
    t_word         r_rot_k;
    logic [DW-2:0] r_dt;

    // valid bits
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld, r_s8_vld;
    logic r_s9_vld, r_s10_vld, r_s11_vld, r_s12_vld, r_s13_vld, r_out_vld;
    logic [QW-1:0] r_dvld;

    // stage payloads
    t_prod r_s1_pk [3];
    t_prod r_s1_pa [3];
    t_prod r_s1_pb [3];
    t_vec  r_s1_x, r_s1_v;

    t_vec  r_s2_t, r_s2_uxb, r_s2_x, r_s2_v;
    logic  r_s2_ov;
    t_vec  n_s2_t, n_s2_uxb;
    logic  n_s2_ov;

    t_prod r_s3_pku [3];
    t_prod r_s3_psq [3];
    t_vec  r_s3_x, r_s3_v, r_s3_t;
    logic  r_s3_ov;

    t_vec  r_s4_x, r_s4_v, r_s4_t, r_s4_r;
    t_word r_s4_den;
    logic  r_s4_ov;
    t_vec  n_s4_r;
    t_word n_s4_den;
    logic  n_s4_ov;

    t_vec  r_s5_x, r_s5_u, r_s5_r, r_s5_t;
    t_word r_s5_den;
    logic  r_s5_ov;
    t_vec  n_s5_u;
    logic  n_s5_ov;

    t_prod r_s6_pa [3];
    t_prod r_s6_pb [3];
    t_vec  r_s6_x, r_s6_u, r_s6_r, r_s6_t;
    t_word r_s6_den;
    logic  r_s6_ov;

    t_vec  r_s7_x, r_s7_u, r_s7_r, r_s7_t, r_s7_c1;
    t_word r_s7_den;
    logic  r_s7_ov;
    t_vec  n_s7_c1;
    logic  n_s7_ov;

    t_vec  r_s8_x, r_s8_u, r_s8_r, r_s8_t, r_s8_vp;
    t_word r_s8_den;
    logic  r_s8_ov;
    t_vec  n_s8_vp;
    logic  n_s8_ov;

    t_side         r_dly [QW];
    t_side         dly_in;
    logic [QW-1:0] quo [3];
    logic [DW:0]   div_num [3];

    t_vec  r_s9_s, r_s9_x, r_s9_u, r_s9_r, r_s9_vp;
    logic  r_s9_ov;
    t_vec  n_s9_s;
    logic  n_s9_ov;

    t_prod r_s10_pa [3];
    t_prod r_s10_pb [3];
    t_vec  r_s10_x, r_s10_u, r_s10_r;
    logic  r_s10_ov;

    t_vec  r_s11_c2, r_s11_x, r_s11_u, r_s11_r;
    logic  r_s11_ov;
    t_vec  n_s11_c2;
    logic  n_s11_ov;

    t_vec  r_s12_vn, r_s12_x;
    logic  r_s12_ov;
    t_vec  n_s12_vn;
    logic  n_s12_ov;

    t_prod r_s13_p [3];
    t_vec  r_s13_vn, r_s13_x;
    logic  r_s13_ov;

    t_vec  r_out_pos, r_out_vel;
    logic  r_out_ov;
    t_vec  n_out_pos;
    logic  n_out_ov;

    // Handshakes: the pipe never stalls, so both channels are always open
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = start && !busy;

    assign in_pos   = {i_pos_z, i_pos_y, i_pos_x};
    assign in_vel   = {i_vel_z, i_vel_y, i_vel_x};
    assign in_flow  = {i_flow_z, i_flow_y, i_flow_x};
    assign in_field = {i_field_z, i_field_y, i_field_x};

    // Configuration writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_k <= '0;
            r_dt    <= ONEQ[DW-2:0];
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ROT_SCALE: r_rot_k <= i_cfg_data;
                REG_TIME_STEP: r_dt    <= i_cfg_data[DW-2:0];
                default: ;
            endcase
        end
    end

    // Valid bits advance one stage per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_dvld    <= '0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
            r_s13_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= in_acc;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= r_s7_vld;
            r_dvld    <= {r_dvld[QW-2:0], r_s8_vld};
            r_s9_vld  <= r_dvld[QW-1];
            r_s10_vld <= r_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
            r_s13_vld <= r_s12_vld;
            r_out_vld <= r_s13_vld;
        end
    end

    // Stage 1: raw products for T = k*B and for U x B
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s1_pk[i] <= mul_raw(r_rot_k, in_field[i]);
            r_s1_pa[i] <= mul_raw(in_flow[NX1[i]], in_field[NX2[i]]);
            r_s1_pb[i] <= mul_raw(in_flow[NX2[i]], in_field[NX1[i]]);
        end
        r_s1_x <= in_pos;
        r_s1_v <= in_vel;
    end

    // Stage 2: round T and finish U x B
    always_comb begin
        t_res a, b, c, d;
        n_s2_ov = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a           = round_sat(r_s1_pk[i]);
            b           = round_sat(r_s1_pa[i]);
            c           = round_sat(r_s1_pb[i]);
            d           = sub_sat(b.val, c.val);
            n_s2_t[i]   = a.val;
            n_s2_uxb[i] = d.val;
            n_s2_ov     = n_s2_ov | a.ov | b.ov | c.ov | d.ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_t   <= n_s2_t;
        r_s2_uxb <= n_s2_uxb;
        r_s2_ov  <= n_s2_ov;
        r_s2_x   <= r_s1_x;
        r_s2_v   <= r_s1_v;
    end

    // Stage 3: raw products for the half kick and for |T|^2
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s3_pku[i] <= mul_raw(r_rot_k, r_s2_uxb[i]);
            r_s3_psq[i] <= mul_raw(r_s2_t[i], r_s2_t[i]);
        end
        r_s3_x  <= r_s2_x;
        r_s3_v  <= r_s2_v;
        r_s3_t  <= r_s2_t;
        r_s3_ov <= r_s2_ov;
    end

    // Stage 4: half kick R = -k*(U x B), and den = 1 + |T|^2. The squares are
    // never negative, so the chained clamps fold into one clamp of the full sum.
    always_comb begin
        t_res          a, b, sq;
        logic [DW+1:0] sum;
        n_s4_ov = r_s3_ov;
        sum     = (DW+2)'(ONEQ);
        for (int i = 0; i < 3; i++) begin
            a         = round_sat(r_s3_pku[i]);
            b         = neg_sat(a.val);
            sq        = round_sat(r_s3_psq[i]);
            n_s4_r[i] = b.val;
            sum       = sum + (DW+2)'(sq.val);
            n_s4_ov   = n_s4_ov | a.ov | b.ov | sq.ov;
        end
        if (sum > (DW+2)'(MAXV)) begin
            n_s4_den = MAXV;
            n_s4_ov  = 1'b1;
        end else begin
            n_s4_den = sum[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_r   <= n_s4_r;
        r_s4_den <= n_s4_den;
        r_s4_ov  <= n_s4_ov;
        r_s4_x   <= r_s3_x;
        r_s4_v   <= r_s3_v;
        r_s4_t   <= r_s3_t;
    end

    // Stage 5: first half kick u = V + R
    always_comb begin
        t_res a;
        n_s5_ov = r_s4_ov;
        for (int i = 0; i < 3; i++) begin
            a         = add_sat(r_s4_v[i], r_s4_r[i]);
            n_s5_u[i] = a.val;
            n_s5_ov   = n_s5_ov | a.ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_u   <= n_s5_u;
        r_s5_ov  <= n_s5_ov;
        r_s5_x   <= r_s4_x;
        r_s5_r   <= r_s4_r;
        r_s5_t   <= r_s4_t;
        r_s5_den <= r_s4_den;
    end

    // Stage 6: raw products for u x T
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s6_pa[i] <= mul_raw(r_s5_u[NX1[i]], r_s5_t[NX2[i]]);
            r_s6_pb[i] <= mul_raw(r_s5_u[NX2[i]], r_s5_t[NX1[i]]);
        end
        r_s6_x   <= r_s5_x;
        r_s6_u   <= r_s5_u;
        r_s6_r   <= r_s5_r;
        r_s6_t   <= r_s5_t;
        r_s6_den <= r_s5_den;
        r_s6_ov  <= r_s5_ov;
    end

    // Stage 7: finish u x T
    always_comb begin
        t_res b, c, d;
        n_s7_ov = r_s6_ov;
        for (int i = 0; i < 3; i++) begin
            b          = round_sat(r_s6_pa[i]);
            c          = round_sat(r_s6_pb[i]);
            d          = sub_sat(b.val, c.val);
            n_s7_c1[i] = d.val;
            n_s7_ov    = n_s7_ov | b.ov | c.ov | d.ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s7_c1  <= n_s7_c1;
        r_s7_ov  <= n_s7_ov;
        r_s7_x   <= r_s6_x;
        r_s7_u   <= r_s6_u;
        r_s7_r   <= r_s6_r;
        r_s7_t   <= r_s6_t;
        r_s7_den <= r_s6_den;
    end

    // Stage 8: V' = u + u x T
    always_comb begin
        t_res a;
        n_s8_ov = r_s7_ov;
        for (int i = 0; i < 3; i++) begin
            a          = add_sat(r_s7_u[i], r_s7_c1[i]);
            n_s8_vp[i] = a.val;
            n_s8_ov    = n_s8_ov | a.ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s8_vp  <= n_s8_vp;
        r_s8_ov  <= n_s8_ov;
        r_s8_x   <= r_s7_x;
        r_s8_u   <= r_s7_u;
        r_s8_r   <= r_s7_r;
        r_s8_t   <= r_s7_t;
        r_s8_den <= r_s7_den;
    end

    // S dividers, one per component: quotient of 2|T| * 2^(FB+1) by den
    for (genvar g = 0; g < 3; g++) begin : g_div
        assign div_num[g] = {mag_of(r_s8_t[g]), 1'b0};

        bpp_div u_div (
            .i_clk (i_clk),
            .i_num (div_num[g]),
            .i_den (r_s8_den[DW-2:0]),
            .o_quo (quo[g])
        );
    end

    // Hold everything else in step with the dividers
    assign dly_in = '{
        x:    r_s8_x,
        u:    r_s8_u,
        r:    r_s8_r,
        vp:   r_s8_vp,
        tneg: {r_s8_t[2][DW-1], r_s8_t[1][DW-1], r_s8_t[0][DW-1]},
        ov:   r_s8_ov
    };

    always_ff @(posedge i_clk) begin
        r_dly[0] <= dly_in;
        for (int k = 1; k < QW; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    // Stage 9: S = round(quotient / 2), signed and clamped
    always_comb begin
        logic [QW-1:0] h;
        logic [QW-1:0] lim;
        logic          neg;
        n_s9_ov = r_dly[QW-1].ov;
        for (int i = 0; i < 3; i++) begin
            neg = r_dly[QW-1].tneg[i];
            h   = (quo[i] + 1'b1) >> 1;
            lim = neg ? QW'(LIM_NEG) : QW'(LIM_POS);
            if (h > lim) begin
                h       = lim;
                n_s9_ov = 1'b1;
            end
            n_s9_s[i] = neg ? t_word'(~h[DW-1:0] + 1'b1) : t_word'(h[DW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s9_s  <= n_s9_s;
        r_s9_ov <= n_s9_ov;
        r_s9_x  <= r_dly[QW-1].x;
        r_s9_u  <= r_dly[QW-1].u;
        r_s9_r  <= r_dly[QW-1].r;
        r_s9_vp <= r_dly[QW-1].vp;
    end

    // Stage 10: raw products for V' x S
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s10_pa[i] <= mul_raw(r_s9_vp[NX1[i]], r_s9_s[NX2[i]]);
            r_s10_pb[i] <= mul_raw(r_s9_vp[NX2[i]], r_s9_s[NX1[i]]);
        end
        r_s10_x  <= r_s9_x;
        r_s10_u  <= r_s9_u;
        r_s10_r  <= r_s9_r;
        r_s10_ov <= r_s9_ov;
    end

    // Stage 11: finish V' x S
    always_comb begin
        t_res b, c, d;
        n_s11_ov = r_s10_ov;
        for (int i = 0; i < 3; i++) begin
            b           = round_sat(r_s10_pa[i]);
            c           = round_sat(r_s10_pb[i]);
            d           = sub_sat(b.val, c.val);
            n_s11_c2[i] = d.val;
            n_s11_ov    = n_s11_ov | b.ov | c.ov | d.ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s11_c2 <= n_s11_c2;
        r_s11_ov <= n_s11_ov;
        r_s11_x  <= r_s10_x;
        r_s11_u  <= r_s10_u;
        r_s11_r  <= r_s10_r;
    end

    // Stage 12: Vnew = (u + V' x S) + R, clamped after each add
    always_comb begin
        t_res a, b;
        n_s12_ov = r_s11_ov;
        for (int i = 0; i < 3; i++) begin
            a           = add_sat(r_s11_u[i], r_s11_c2[i]);
            b           = add_sat(a.val, r_s11_r[i]);
            n_s12_vn[i] = b.val;
            n_s12_ov    = n_s12_ov | a.ov | b.ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s12_vn <= n_s12_vn;
        r_s12_ov <= n_s12_ov;
        r_s12_x  <= r_s11_x;
    end

    // Stage 13: raw products Vnew * dt
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s13_p[i] <= mul_raw(r_s12_vn[i], t_word'({1'b0, r_dt}));
        end
        r_s13_vn <= r_s12_vn;
        r_s13_x  <= r_s12_x;
        r_s13_ov <= r_s12_ov;
    end

    // Output stage: Xnew = X + Vnew*dt
    always_comb begin
        t_res a, b;
        n_out_ov = r_s13_ov;
        for (int i = 0; i < 3; i++) begin
            a            = round_sat(r_s13_p[i]);
            b            = add_sat(r_s13_x[i], a.val);
            n_out_pos[i] = b.val;
            n_out_ov     = n_out_ov | a.ov | b.ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pos <= n_out_pos;
        r_out_vel <= r_s13_vn;
        r_out_ov  <= n_out_ov;
    end

    assign o_done      = r_out_vld;
    assign o_new_pos_x = r_out_pos[0];
    assign o_new_pos_y = r_out_pos[1];
    assign o_new_pos_z = r_out_pos[2];
    assign o_new_vel_x = r_out_vel[0];
    assign o_new_vel_y = r_out_vel[1];
    assign o_new_vel_z = r_out_vel[2];
    assign o_overflow  = r_out_ov;

    // Every transfer is followed by its result on o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##LAT o_done)
        else $error("result missing at fixed latency");

    // No result without a matching earlier transfer
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |-> ##LAT !o_done)
        else $error("result without a transfer");

    // The S divisor is never below 1.0
    a_den_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld |-> (r_s4_den >= ONEQ))
        else $error("divisor below one");

    // The divider sideband and the output stage agree on valid items
    a_dly_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dvld[QW-1] |-> ##6 o_done)
        else $error("divider sideband out of step");

endmodule
